>>> rtl/lcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// shared types and constants of the longest common subsequence engine
// ----------------------------------------------------------------------------
`default_nettype none

package lcs_pkg;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 6;
  localparam int OP_W       = 2;
  localparam int OUT_DATA_W = 16;
  localparam int RESULT_CAP = 32;

  localparam logic [OP_W-1:0] OP_APPEND_X = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_Y = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN      = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_TB_START,
    ST_TB_RV,
    ST_TB_RD,
    ST_TB_RL,
    ST_TB_RU,
    ST_TB_DEC,
    ST_OUT_START,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_EMPTY,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/lcs_table_and_traceback.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_table_and_traceback
// longest common subsequence engine: string load, score table fill in ram,
// traceback walk and forward-order emission of the subsequence
// ----------------------------------------------------------------------------
// append requests (op 0/1) are accepted one per cycle while the engine is idle.
// a compute request (op 2) holds in_tready low through the table fill
// (one table ram read then one write per cell), the traceback walk
// (at most m+n steps, four table reads each) and the result emission.
// reset clears the state machine, string lengths, overflow flag and output
// valid; string, score and result stores are not cleared.
`default_nettype none

module lcs_table_and_traceback #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,  // [7:0] char_in
  input  wire logic [lcs_pkg::OP_W-1:0]       in_tuser,  // [1:0] op
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [7:0] lcs_char, [13:8] match_len, [14] overflow, [15] zero
  output logic [lcs_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser, // [0] found
  output logic                                out_tlast
);

  localparam int DIM = MAX_LEN + 1;
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TAW = $clog2(DIM * DIM);
  localparam int VW  = CW;

  function automatic logic [TAW-1:0] tab_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    tab_addr = TAW'(r) * TAW'(DIM) + TAW'(c);
  endfunction

  lcs_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] x_count_r, y_count_r;
  logic          ovf_r;
  logic [CW-1:0] i_r, j_r, i_m1, j_m1;
  logic [VW-1:0] left_r, diag_r, v_r, d_r, l_r, total_r;
  logic [CW-1:0] pos_r, pos_m1, k_r, count_r;
  logic          first_r, rz_r;

  logic                             out_valid_r;
  logic [lcs_pkg::CHAR_W-1:0]       out_char_r;
  logic                             out_found_r;
  logic [lcs_pkg::LEN_W-1:0]        out_len_r;
  logic                             out_last_r;
  logic                             out_ovf_r;

  // memory ports
  logic                       str_we_x, str_we_y;
  logic [AW-1:0]              str_waddr;
  logic [lcs_pkg::CHAR_W-1:0] x_rdata, y_rdata;
  logic                       tab_we;
  logic [TAW-1:0]             tab_waddr, tab_raddr;
  logic [VW-1:0]              tab_wdata, tab_rdata;
  logic                       rd_zero;
  logic                       rev_we;
  logic [lcs_pkg::CHAR_W-1:0] rev_mem [MAX_LEN];
  logic [lcs_pkg::CHAR_W-1:0] rev_rdata_r;

  // datapath
  logic                       in_fire, op_x, op_y, op_run;
  logic                       x_room, y_room;
  logic [VW-1:0]              tab_q, fill_max, fill_v, vm1;
  logic                       take_diag, go_left, go_up;
  logic                       slot_free, last_k, out_load;
  logic [CW-1:0]              i_step, j_step;

  assign in_fire = in_tvalid && in_tready;
  assign op_x    = in_tuser == lcs_pkg::OP_APPEND_X;
  assign op_y    = in_tuser == lcs_pkg::OP_APPEND_Y;
  assign op_run  = in_tuser == lcs_pkg::OP_RUN;
  assign x_room  = x_count_r < CW'(MAX_LEN);
  assign y_room  = y_count_r < CW'(MAX_LEN);

  assign i_m1   = i_r - 1'b1;
  assign j_m1   = j_r - 1'b1;
  assign pos_m1 = pos_r - 1'b1;

  // row 0 and column 0 read as zero without ever being stored
  assign tab_q    = rz_r ? '0 : tab_rdata;
  assign fill_max = (tab_q >= left_r) ? tab_q : left_r;
  assign fill_v   = (x_rdata == y_rdata) ? diag_r + 1'b1 : fill_max;

  assign vm1       = v_r - 1'b1;
  assign take_diag = (v_r != '0) && (d_r == vm1) && (l_r == vm1) && (tab_q == vm1);
  assign go_left   = l_r == v_r;
  assign go_up     = tab_q == v_r;
  assign i_step    = (take_diag || (!go_left && go_up)) ? i_m1 : i_r;
  assign j_step    = (take_diag || go_left || !go_up) ? j_m1 : j_r;

  assign slot_free = !out_valid_r || out_tready;
  assign last_k    = (k_r + 1'b1) == count_r;

  lcs_strings #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_strings (
    .clk     (clk),
    .we_x    (str_we_x),
    .we_y    (str_we_y),
    .waddr   (str_waddr),
    .wdata   (in_tdata),
    .raddr_x (i_m1[AW-1:0]),
    .raddr_y (j_m1[AW-1:0]),
    .rdata_x (x_rdata),
    .rdata_y (y_rdata)
  );

  lcs_score_ram #(
    .DEPTH (DIM * DIM),
    .AW    (TAW),
    .DW    (VW)
  ) u_score (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // result characters, written backward during the walk
  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[pos_m1[AW-1:0]] <= x_rdata;
    end
    rev_rdata_r <= rev_mem[k_r[AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcs_pkg::ST_IDLE: begin
        if (in_fire && op_run) begin
          state_nxt = (x_count_r == '0 || y_count_r == '0) ? lcs_pkg::ST_TB_START
                                                           : lcs_pkg::ST_FILL_RD;
        end
      end
      lcs_pkg::ST_FILL_RD: state_nxt = lcs_pkg::ST_FILL_WR;
      lcs_pkg::ST_FILL_WR: begin
        if (j_r == y_count_r && i_r == x_count_r) begin
          state_nxt = lcs_pkg::ST_TB_START;
        end else begin
          state_nxt = lcs_pkg::ST_FILL_RD;
        end
      end
      lcs_pkg::ST_TB_START: begin
        state_nxt = (x_count_r == '0 || y_count_r == '0) ? lcs_pkg::ST_OUT_START
                                                         : lcs_pkg::ST_TB_RV;
      end
      lcs_pkg::ST_TB_RV:  state_nxt = lcs_pkg::ST_TB_RD;
      lcs_pkg::ST_TB_RD:  state_nxt = lcs_pkg::ST_TB_RL;
      lcs_pkg::ST_TB_RL:  state_nxt = lcs_pkg::ST_TB_RU;
      lcs_pkg::ST_TB_RU:  state_nxt = lcs_pkg::ST_TB_DEC;
      lcs_pkg::ST_TB_DEC: begin
        state_nxt = (i_step == '0 || j_step == '0) ? lcs_pkg::ST_OUT_START
                                                   : lcs_pkg::ST_TB_RV;
      end
      lcs_pkg::ST_OUT_START: begin
        state_nxt = (total_r == '0) ? lcs_pkg::ST_OUT_EMPTY : lcs_pkg::ST_OUT_RD;
      end
      lcs_pkg::ST_OUT_RD: state_nxt = lcs_pkg::ST_OUT_LD;
      lcs_pkg::ST_OUT_LD: begin
        if (slot_free) begin
          state_nxt = last_k ? lcs_pkg::ST_FINISH : lcs_pkg::ST_OUT_RD;
        end
      end
      lcs_pkg::ST_OUT_EMPTY: begin
        if (slot_free) begin
          state_nxt = lcs_pkg::ST_FINISH;
        end
      end
      lcs_pkg::ST_FINISH: state_nxt = lcs_pkg::ST_IDLE;
      default:            state_nxt = lcs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    str_we_x  = 1'b0;
    str_we_y  = 1'b0;
    str_waddr = x_count_r[AW-1:0];
    tab_we    = 1'b0;
    tab_waddr = tab_addr(i_r, j_r);
    tab_wdata = fill_v;
    tab_raddr = '0;
    rd_zero   = 1'b0;
    rev_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      lcs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        str_we_x  = in_fire && op_x && x_room;
        str_we_y  = in_fire && op_y && y_room;
        str_waddr = op_y ? y_count_r[AW-1:0] : x_count_r[AW-1:0];
      end
      lcs_pkg::ST_FILL_RD: begin
        tab_raddr = tab_addr(i_m1, j_r);
        rd_zero   = i_r == CW'(1);
      end
      lcs_pkg::ST_FILL_WR: tab_we = 1'b1;
      lcs_pkg::ST_TB_RV:   tab_raddr = tab_addr(i_r, j_r);
      lcs_pkg::ST_TB_RD: begin
        tab_raddr = tab_addr(i_m1, j_m1);
        rd_zero   = (i_r == CW'(1)) || (j_r == CW'(1));
      end
      lcs_pkg::ST_TB_RL: begin
        tab_raddr = tab_addr(i_r, j_m1);
        rd_zero   = j_r == CW'(1);
      end
      lcs_pkg::ST_TB_RU: begin
        tab_raddr = tab_addr(i_m1, j_r);
        rd_zero   = i_r == CW'(1);
      end
      lcs_pkg::ST_TB_DEC:    rev_we   = take_diag && (pos_r != '0);
      lcs_pkg::ST_OUT_LD:    out_load = slot_free;
      lcs_pkg::ST_OUT_EMPTY: out_load = slot_free;
      lcs_pkg::ST_TB_START, lcs_pkg::ST_OUT_START, lcs_pkg::ST_OUT_RD,
      lcs_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcs_pkg::ST_IDLE;
      x_count_r   <= '0;
      y_count_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == lcs_pkg::ST_FINISH) begin
        x_count_r <= '0;
        y_count_r <= '0;
        ovf_r     <= 1'b0;
      end else begin
        if (str_we_x) begin
          x_count_r <= x_count_r + 1'b1;
        end
        if (str_we_y) begin
          y_count_r <= y_count_r + 1'b1;
        end
        if (in_fire && ((op_x && !x_room) || (op_y && !y_room))) begin
          ovf_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rz_r <= rd_zero;
    unique case (state_r)
      lcs_pkg::ST_IDLE: begin
        i_r    <= CW'(1);
        j_r    <= CW'(1);
        left_r <= '0;
        diag_r <= '0;
      end
      lcs_pkg::ST_FILL_WR: begin
        if (j_r == y_count_r) begin
          i_r    <= i_r + 1'b1;
          j_r    <= CW'(1);
          left_r <= '0;
          diag_r <= '0;
        end else begin
          j_r    <= j_r + 1'b1;
          left_r <= fill_v;
          diag_r <= tab_q;
        end
      end
      lcs_pkg::ST_TB_START: begin
        i_r     <= x_count_r;
        j_r     <= y_count_r;
        first_r <= 1'b1;
        total_r <= '0;
      end
      lcs_pkg::ST_TB_RD: begin
        v_r <= tab_q;
        if (first_r) begin
          total_r <= tab_q;
          pos_r   <= tab_q;
          first_r <= 1'b0;
        end
      end
      lcs_pkg::ST_TB_RL: d_r <= tab_q;
      lcs_pkg::ST_TB_RU: l_r <= tab_q;
      lcs_pkg::ST_TB_DEC: begin
        i_r <= i_step;
        j_r <= j_step;
        if (take_diag && pos_r != '0) begin
          pos_r <= pos_m1;
        end
      end
      lcs_pkg::ST_OUT_START: begin
        k_r     <= '0;
        count_r <= (int'(total_r) > lcs_pkg::RESULT_CAP) ? CW'(lcs_pkg::RESULT_CAP)
                                                         : total_r;
      end
      lcs_pkg::ST_OUT_LD: begin
        if (slot_free) begin
          k_r <= k_r + 1'b1;
        end
      end
      lcs_pkg::ST_TB_RV, lcs_pkg::ST_FILL_RD, lcs_pkg::ST_OUT_RD,
      lcs_pkg::ST_OUT_EMPTY, lcs_pkg::ST_FINISH: begin
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_ovf_r <= ovf_r;
      if (state_r == lcs_pkg::ST_OUT_EMPTY) begin
        out_char_r  <= '0;
        out_found_r <= 1'b0;
        out_len_r   <= '0;
        out_last_r  <= 1'b1;
      end else begin
        out_char_r  <= rev_rdata_r;
        out_found_r <= 1'b1;
        out_len_r   <= lcs_pkg::LEN_W'(total_r);
        out_last_r  <= last_k;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ovf_r, out_len_r, out_char_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/lcs_strings.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_strings
// character stores of both input strings, one write and two registered reads
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_strings #(
  parameter int MAX_LEN = 32,
  parameter int AW      = 5
) (
  input  wire logic                       clk,
  input  wire logic                       we_x,
  input  wire logic                       we_y,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [lcs_pkg::CHAR_W-1:0] wdata,
  input  wire logic [AW-1:0]              raddr_x,
  input  wire logic [AW-1:0]              raddr_y,
  output logic      [lcs_pkg::CHAR_W-1:0] rdata_x,
  output logic      [lcs_pkg::CHAR_W-1:0] rdata_y
);

  logic [lcs_pkg::CHAR_W-1:0] x_mem [MAX_LEN];
  logic [lcs_pkg::CHAR_W-1:0] y_mem [MAX_LEN];
  logic [lcs_pkg::CHAR_W-1:0] rdata_x_r;
  logic [lcs_pkg::CHAR_W-1:0] rdata_y_r;

  always_ff @(posedge clk) begin
    if (we_x) begin
      x_mem[waddr] <= wdata;
    end
    if (we_y) begin
      y_mem[waddr] <= wdata;
    end
    rdata_x_r <= x_mem[raddr_x];
    rdata_y_r <= y_mem[raddr_y];
  end

  assign rdata_x = rdata_x_r;
  assign rdata_y = rdata_y_r;

endmodule

`default_nettype wire

>>> rtl/lcs_score_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_score_ram
// score table storage, one write port and one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_score_ram #(
  parameter int DEPTH = 1089,
  parameter int AW    = 11,
  parameter int DW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/lcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lcs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lcs_pkg::OUT_DATA_W-1:0]    out_tdata,
  input wire logic                              out_tuser,
  input wire logic                              out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // an empty subsequence is a single closing result beat
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[13:0] == 14'd0)
    else $error("empty result malformed");

  // no result appears out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a new result only follows while the engine is busy with a run
  a_new_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> !$past(in_tready))
    else $error("result launched from idle");

endmodule

bind lcs_table_and_traceback lcs_checker u_lcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
